>>> rtl/core/dtst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtst_pkg
// Types, register codes and zone geometry tables for the track/sector
// translator.
// ----------------------------------------------------------------------------
package dtst_pkg;

	localparam int NumFormats = 4;
	localparam int MaxZones   = 8;

	localparam logic [1:0] REG_DISK_FORMAT     = 2'd0;
	localparam logic [1:0] REG_DIRECTORY_TRACK = 2'd1;
	localparam logic [1:0] REG_SECTOR_INTERLV  = 2'd2;
	localparam logic [1:0] REG_DIR_INTERLV     = 2'd3;

	typedef struct packed {
		logic [7:0] track;
		logic [7:0] sector;
	} in_item_t;

	typedef struct packed {
		logic        track_ok;
		logic        sector_ok;
		logic [5:0]  sectors_in_track;
		logic [11:0] block_index;
		logic [19:0] byte_offset;
		logic [5:0]  next_sector;
		logic        next_ok;
	} out_item_t;

	typedef struct packed {
		logic [1:0] disk_format;
		logic [6:0] directory_track;
		logic [5:0] sector_interleave;
		logic [5:0] dir_interleave;
	} cfg_t;

	// stage 1 -> stage 2
	typedef struct packed {
		logic        found;
		logic [7:0]  sector;
		logic [6:0]  offs;
		logic [5:0]  count;
		logic [11:0] base;
		logic [5:0]  step;
	} zone_item_t;

	// stage 2 -> stage 3
	typedef struct packed {
		logic        found;
		logic        sector_ok;
		logic [5:0]  count;
		logic [11:0] block;
		logic [8:0]  rem;
	} calc_item_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  first;
		logic [5:0]  count;
		logic [11:0] base;
	} zone_hit_t;

	localparam logic [3:0] ZONE_TOTAL [NumFormats] = '{4'd4, 4'd4, 4'd8, 4'd1};

	localparam logic [11:0] DISK_BLOCKS [NumFormats] =
		'{12'd683, 12'd768, 12'd1366, 12'd3200};

	localparam logic [6:0] ZONE_FIRST [NumFormats][MaxZones] = '{
		'{7'd1, 7'd18, 7'd25, 7'd31, 7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd1, 7'd18, 7'd25, 7'd31, 7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd1, 7'd18, 7'd25, 7'd31, 7'd36, 7'd53, 7'd60, 7'd66},
		'{7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0}
	};

	localparam logic [6:0] ZONE_LAST [NumFormats][MaxZones] = '{
		'{7'd17, 7'd24, 7'd30, 7'd35, 7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd17, 7'd24, 7'd30, 7'd40, 7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd17, 7'd24, 7'd30, 7'd35, 7'd52, 7'd59, 7'd65, 7'd70},
		'{7'd80, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0}
	};

	localparam logic [5:0] ZONE_COUNT [NumFormats][MaxZones] = '{
		'{6'd21, 6'd19, 6'd18, 6'd17, 6'd0,  6'd0,  6'd0,  6'd0},
		'{6'd21, 6'd19, 6'd18, 6'd17, 6'd0,  6'd0,  6'd0,  6'd0},
		'{6'd21, 6'd19, 6'd18, 6'd17, 6'd21, 6'd19, 6'd18, 6'd17},
		'{6'd40, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0}
	};

	// blocks ahead of each zone
	localparam logic [11:0] ZONE_BASE [NumFormats][MaxZones] = '{
		'{12'd0, 12'd357, 12'd490, 12'd598, 12'd0,   12'd0,    12'd0,    12'd0},
		'{12'd0, 12'd357, 12'd490, 12'd598, 12'd0,   12'd0,    12'd0,    12'd0},
		'{12'd0, 12'd357, 12'd490, 12'd598, 12'd683, 12'd1040, 12'd1173, 12'd1281},
		'{12'd0, 12'd0,   12'd0,   12'd0,   12'd0,   12'd0,    12'd0,    12'd0}
	};

	// first matching zone wins; an unmatched track reports the disk size as base
	function automatic zone_hit_t zone_lookup(logic [1:0] fmt, logic [7:0] track);
		zone_hit_t hit;
		hit.found = 1'b0;
		hit.first = '0;
		hit.count = '0;
		hit.base  = DISK_BLOCKS[fmt];
		for (int z = MaxZones - 1; z >= 0; z--) begin
			if ((4'(z) < ZONE_TOTAL[fmt]) &&
			    (track >= {1'b0, ZONE_FIRST[fmt][z]}) &&
			    (track <= {1'b0, ZONE_LAST[fmt][z]})) begin
				hit.found = 1'b1;
				hit.first = ZONE_FIRST[fmt][z];
				hit.count = ZONE_COUNT[fmt][z];
				hit.base  = ZONE_BASE[fmt][z];
			end
		end
		return hit;
	endfunction

	// one restoring step of the remainder
	function automatic logic [8:0] mod_step(logic [8:0] r, logic [9:0] d);
		logic [8:0] res;
		res = r;
		if ({1'b0, r} >= d)
			res = r - d[8:0];
		return res;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/dtst_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtst_apb_regs
// APB register file holding format, directory track and interleave steps.
// ----------------------------------------------------------------------------
module dtst_apb_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output dtst_pkg::cfg_t    cfg
);
	import dtst_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disk_format       <= 2'd0;
			cfg_q.directory_track   <= 7'd18;
			cfg_q.sector_interleave <= 6'd10;
			cfg_q.dir_interleave    <= 6'd3;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DISK_FORMAT:     cfg_q.disk_format       <= pwdata[1:0];
				REG_DIRECTORY_TRACK: cfg_q.directory_track   <= pwdata[6:0];
				REG_SECTOR_INTERLV:  cfg_q.sector_interleave <= pwdata[5:0];
				REG_DIR_INTERLV:     cfg_q.dir_interleave    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DISK_FORMAT:     prdata = {30'd0, cfg_q.disk_format};
			REG_DIRECTORY_TRACK: prdata = {25'd0, cfg_q.directory_track};
			REG_SECTOR_INTERLV:  prdata = {26'd0, cfg_q.sector_interleave};
			REG_DIR_INTERLV:     prdata = {26'd0, cfg_q.dir_interleave};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/dtst_zone_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtst_zone_stage
// Stage 1: zone lookup, track offset within zone and interleave selection.
// ----------------------------------------------------------------------------
module dtst_zone_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 vld_i,
	input  wire dtst_pkg::in_item_t   data_i,
	input  wire dtst_pkg::cfg_t       cfg,
	output logic                      vld_o,
	output dtst_pkg::zone_item_t      data_o
);
	import dtst_pkg::*;

	logic       vld_s1;
	zone_item_t data_s1;
	zone_item_t nxt;
	zone_hit_t  hit;
	logic [7:0] offs_full;

	always_comb begin
		hit       = zone_lookup(cfg.disk_format, data_i.track);
		offs_full = data_i.track - {1'b0, hit.first};
		nxt.found  = hit.found;
		nxt.sector = data_i.sector;
		nxt.offs   = hit.found ? offs_full[6:0] : 7'd0;
		nxt.count  = hit.count;
		nxt.base   = hit.base;
		nxt.step   = (data_i.track == {1'b0, cfg.directory_track}) ?
		             cfg.dir_interleave : cfg.sector_interleave;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (adv && vld_i)
			data_s1 <= nxt;
	end

	assign vld_o  = vld_s1;
	assign data_o = data_s1;

endmodule
`default_nettype wire

>>> rtl/core/dtst_calc_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtst_calc_stage
// Stage 2: block index multiply-add, sector check and upper remainder steps.
// ----------------------------------------------------------------------------
module dtst_calc_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  vld_i,
	input  wire dtst_pkg::zone_item_t  data_i,
	output logic                       vld_o,
	output dtst_pkg::calc_item_t       data_o
);
	import dtst_pkg::*;

	logic        vld_s2;
	calc_item_t  data_s2;
	calc_item_t  nxt;
	logic [12:0] prod;
	logic [8:0]  sum;
	logic [8:0]  r4;

	always_comb begin
		prod = {6'd0, data_i.offs} * {7'd0, data_i.count};
		sum  = {1'b0, data_i.sector} + {3'd0, data_i.step};
		r4   = mod_step(sum, {4'd0, data_i.count} << 4);
		nxt.found     = data_i.found;
		nxt.sector_ok = data_i.found && (data_i.sector < {2'd0, data_i.count});
		nxt.count     = data_i.count;
		nxt.block     = data_i.found ?
		                12'(data_i.base + prod[11:0] + {4'd0, data_i.sector}) :
		                data_i.base;
		nxt.rem       = mod_step(r4, {4'd0, data_i.count} << 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (adv && vld_i)
			data_s2 <= nxt;
	end

	assign vld_o  = vld_s2;
	assign data_o = data_s2;

endmodule
`default_nettype wire

>>> rtl/core/dtst_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtst_out_stage
// Stage 3: lower remainder steps and the result register.
// ----------------------------------------------------------------------------
module dtst_out_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  vld_i,
	input  wire dtst_pkg::calc_item_t  data_i,
	output logic                       vld_o,
	output dtst_pkg::out_item_t        data_o
);
	import dtst_pkg::*;

	logic      vld_s3;
	out_item_t data_s3;
	out_item_t nxt;
	logic [8:0] r2;
	logic [8:0] r1;
	logic [8:0] r0;

	always_comb begin
		r2 = mod_step(data_i.rem, {4'd0, data_i.count} << 2);
		r1 = mod_step(r2, {4'd0, data_i.count} << 1);
		r0 = mod_step(r1, {4'd0, data_i.count});
		nxt.track_ok         = data_i.found;
		nxt.sector_ok        = data_i.sector_ok;
		nxt.sectors_in_track = data_i.count;
		nxt.block_index      = data_i.block;
		nxt.byte_offset      = {data_i.block, 8'd0};
		nxt.next_sector      = data_i.found ? r0[5:0] : 6'd0;
		nxt.next_ok          = data_i.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv)
			vld_s3 <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (adv && vld_i)
			data_s3 <= nxt;
	end

	assign vld_o  = vld_s3;
	assign data_o = data_s3;

endmodule
`default_nettype wire

>>> rtl/core/disk_track_sector_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disk_track_sector_translator
// Zoned track/sector to block address translator, three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+--------------------
//  in       | in_valid, in_ready, in_data               | track, sector
//  out      | out_valid, out_ready, out_data            | one result/transfer
//  apb      | psel, penable, pwrite, paddr, pwdata, ... | register writes
//
//  One transfer per cycle sustained while out_ready is held high; depth
//  set by the zone lookup, the block multiply-add and the five-step
//  remainder split over stages 2 and 3.
//  Reset clears the stage valid bits and loads register defaults.
//  Each stage advances when empty or when the stage after it advances.
// ----------------------------------------------------------------------------
module disk_track_sector_translator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire dtst_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output dtst_pkg::out_item_t       out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import dtst_pkg::*;

	cfg_t       cfg;
	logic       vld1;
	logic       vld2;
	zone_item_t zone_d;
	calc_item_t calc_d;
	logic       adv1;
	logic       adv2;
	logic       adv3;

	assign adv3     = !out_valid || out_ready;
	assign adv2     = !vld2 || adv3;
	assign adv1     = !vld1 || adv2;
	assign in_ready = adv1;

	dtst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtst_zone_stage u_zone (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv1),
		.vld_i  (in_valid),
		.data_i (in_data),
		.cfg    (cfg),
		.vld_o  (vld1),
		.data_o (zone_d)
	);

	dtst_calc_stage u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv2),
		.vld_i  (vld1),
		.data_i (zone_d),
		.vld_o  (vld2),
		.data_o (calc_d)
	);

	dtst_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv3),
		.vld_i  (vld2),
		.data_i (calc_d),
		.vld_o  (out_valid),
		.data_o (out_data)
	);

	// a full pipeline is the only reason to refuse a transfer
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld1 && vld2 && out_valid && !out_ready))
		else $error("input stalled with a bubble in the pipeline");

	a_ok_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.next_ok == out_data.track_ok) &&
		              (!out_data.sector_ok || out_data.track_ok))
		else $error("validity flags inconsistent");

	a_bad_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.track_ok) |->
		(out_data.sectors_in_track == 6'd0) && (out_data.next_sector == 6'd0))
		else $error("invalid track result not cleared");

	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.track_ok) |->
		(out_data.next_sector < out_data.sectors_in_track))
		else $error("next sector beyond track");

endmodule
`default_nettype wire
